### hw/rtl/vc_pkg.sv
// Shared types and constants for the LEB128 varint codec.
package vc_pkg;

  // Largest number of bytes in one encoded value.
  localparam int unsigned MAX_BYTES_DEF = 9;

  // Request codes.
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [63:0] value;
    logic [7:0]  data_byte;
    logic        buffer_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [62:0] out_value;
    logic [3:0]  out_length;
    logic        run_last;
  } out_item_t;

  // Controller -> datapath.
  typedef struct packed {
    logic load;      // capture the accepted item
    logic enc_step;  // emit next encoded byte (or the range error)
    logic dec_step;  // run one decode step, emit if it has a result
  } cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic enc_last;    // the pending encode result is the final one
    logic dec_result;  // the pending decode step produces a result
  } stat_t;

endpackage

### hw/rtl/vc_datapath.sv
// Datapath of the varint codec: encode shifter, decode accumulator, result register.
module vc_datapath #(
  parameter int unsigned MAX_BYTES = vc_pkg::MAX_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vc_pkg::in_item_t in_item_i,
  input  vc_pkg::cmd_t     cmd_i,
  output vc_pkg::stat_t    stat_o,
  output vc_pkg::out_item_t out_item_o
);

  localparam logic [3:0] MaxBytes = 4'(MAX_BYTES);

  logic [62:0] shift_q, shift_d;
  logic        big_q;
  logic [7:0]  byte_q;
  logic        blast_q;
  logic [62:0] acc_q, acc_d;
  logic [3:0]  seen_q, seen_d;
  vc_pkg::out_item_t out_q, out_d;

  logic [6:0]  bit_off;
  logic [62:0] acc_new;
  logic [3:0]  seen_inc;
  logic        zero_err, over_err, trunc_err, dec_err, dec_done, enc_more;
  vc_pkg::out_item_t enc_res, dec_res;

  always_comb begin
    // offset = 7 * bytes seen
    bit_off   = {seen_q, 3'b000} - {3'b000, seen_q};
    acc_new   = acc_q | (63'(byte_q[6:0]) << bit_off);
    seen_inc  = seen_q + 4'd1;
    zero_err  = (seen_q != 4'd0) && (byte_q == 8'd0);
    over_err  = (seen_q >= MaxBytes);
    trunc_err = byte_q[7] && ((seen_inc >= MaxBytes) || blast_q);
    dec_err   = zero_err || over_err || trunc_err;
    dec_done  = !zero_err && !over_err && !byte_q[7];

    enc_more  = (shift_q[62:7] != 56'd0);

    enc_res = '0;
    if (big_q) begin
      enc_res.out_kind = vc_pkg::KIND_ERROR;
      enc_res.run_last = 1'b1;
    end else begin
      enc_res.out_kind = vc_pkg::KIND_BYTE;
      enc_res.out_byte = {enc_more, shift_q[6:0]};
      enc_res.run_last = !enc_more;
    end

    dec_res = '0;
    dec_res.run_last = 1'b1;
    if (dec_err) begin
      dec_res.out_kind = vc_pkg::KIND_ERROR;
    end else begin
      dec_res.out_kind   = vc_pkg::KIND_VALUE;
      dec_res.out_value  = acc_new;
      dec_res.out_length = seen_inc;
    end

    stat_o.enc_last   = big_q || !enc_more;
    stat_o.dec_result = dec_err || dec_done;

    shift_d = cmd_i.load ? in_item_i.value[62:0] : (shift_q >> 7);

    acc_d  = acc_q;
    seen_d = seen_q;
    if (cmd_i.dec_step) begin
      if (dec_err || dec_done) begin
        acc_d  = '0;
        seen_d = '0;
      end else begin
        acc_d  = acc_new;
        seen_d = seen_inc;
      end
    end

    out_d = cmd_i.enc_step ? enc_res : dec_res;
  end

  // Item capture, encode shifter and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      big_q   <= in_item_i.value[63];
      byte_q  <= in_item_i.data_byte;
      blast_q <= in_item_i.buffer_last;
    end
    if (cmd_i.load || cmd_i.enc_step) begin
      shift_q <= shift_d;
    end
    if (cmd_i.enc_step || (cmd_i.dec_step && stat_o.dec_result)) begin
      out_q <= out_d;
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= '0;
    end else begin
      acc_q  <= acc_d;
      seen_q <= seen_d;
    end
  end

  assign out_item_o = out_q;

endmodule

### hw/rtl/vc_ctrl.sv
// Controller of the varint codec: sequencing and both handshakes.
module vc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vc_pkg::cmd_t  cmd_o,
  input  vc_pkg::stat_t stat_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ENC  = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free, emit;

  always_comb begin
    slot_free      = !out_valid_q || !out_stall_i;
    in_stall_o     = (state_q != ST_IDLE);
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.enc_step = (state_q == ST_ENC) && slot_free;
    cmd_o.dec_step = (state_q == ST_DEC) && slot_free;
    emit           = cmd_o.enc_step || (cmd_o.dec_step && stat_i.dec_result);

    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end

    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (req_type_i == vc_pkg::REQ_DECODE) ? ST_DEC : ST_ENC;
        end
      end
      ST_ENC: begin
        if (cmd_o.enc_step && stat_i.enc_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_DEC: begin
        if (cmd_o.dec_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/varint_codec_unit.sv
// Top level of the unsigned LEB128 varint encoder and streaming decoder.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one item per request.
//   Encode items carry a 64-bit value; decode items carry one byte plus a
//   flag marking the last byte of the buffer.
// Output channel (out_valid_o / out_stall_i / out_item_o): result items.
//   An encode gives 1 to 9 byte items (one error item for values of 2^63
//   and up); a decode byte gives a value item, an error item, or nothing
//   while a number is still open. run_last flags the final result of an item.
// Timing: an item is taken in the idle state; each result then takes its own
//   encode or decode step. The first result follows accept via the state
//   and output registers. The rate is set by the single output register:
//   one result per cycle in an encode run, while the output is not stalled.
// The input is stalled while an item is being worked on. A new item may be
//   taken while the last result still waits in the output register.
// A stalled output freezes the sequencer; nothing is dropped.
// Reset clears the decoder accumulator and byte count, the sequencer and
//   the output valid; no clearing pass is needed.
module varint_codec_unit #(
  parameter int unsigned MAX_BYTES = vc_pkg::MAX_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vc_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vc_pkg::out_item_t out_item_o
);

  vc_pkg::cmd_t  cmd;
  vc_pkg::stat_t stat;

  // Sequencer: idle -> encode (a byte per unstalled cycle) or decode (one step).
  vc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_item_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Shifter, accumulator and result register.
  vc_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

### hw/rtl/vc_checker.sv
// Port-level checks for the varint codec, bound to the top level.
module vc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input vc_pkg::out_item_t out_item_o
);

  // Held result stays put while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // One item at a time: after an accept the input is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after accept");

  // A non-final encoded byte means the encoder still owns the block.
  a_enc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.out_kind == vc_pkg::KIND_BYTE) && !out_item_o.run_last
      |-> in_stall_o && out_item_o.out_byte[7])
    else $error("open encode run without busy input");

  // Decoded values and errors are always single, final results.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.out_kind == vc_pkg::KIND_VALUE) ||
                    (out_item_o.out_kind == vc_pkg::KIND_ERROR))
      |-> out_item_o.run_last && (out_item_o.out_byte == 8'd0))
    else $error("value or error result not final");

endmodule

bind varint_codec_unit vc_checker u_vc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
